// ----- rtl/pdec_pkg.sv -----
// Package: constants, register codes and shared types of the PPM and echo pulse decoder
`timescale 1ns / 1ps
package pdec_pkg;

   localparam int unsigned TIME_W       = 16;
   localparam int unsigned CHAN_W       = 3;
   localparam int unsigned INDEX_W      = 4;
   localparam int unsigned STORE_DEPTH  = 8;
   localparam int unsigned MAX_CHANNELS = 8;
   localparam int unsigned CSR_IDX_W    = 2;

   localparam logic [TIME_W-1:0] RST_SYNC_GAP  = 16'd2700;
   localparam logic [TIME_W-1:0] RST_MIN_WIDTH = 16'd750;
   localparam logic [TIME_W-1:0] RST_MAX_WIDTH = 16'd2250;
   localparam logic [TIME_W-1:0] WIDTH_CENTER  = 16'd1500;
   localparam logic [TIME_W-1:0] TIMER_TOP     = 16'hFFFF;

   localparam logic [1:0] CMD_SONAR = 2'd0;
   localparam logic [1:0] CMD_PPM   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_GAP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WIDTH = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0] sync_gap;
      logic [TIME_W-1:0] min_width;
      logic [TIME_W-1:0] max_width;
   } ppm_cfg_type;

   typedef struct packed {
      logic               active;
      logic [INDEX_W-1:0] index;
   } ppm_status_type;

endpackage

// ----- rtl/pdec_req_if.sv -----
// Interfaces: capture request channel and result channel
`timescale 1ns / 1ps
interface pdec_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] capture_time;
   logic [2:0]  read_channel;

   modport source (output valid, output cmd, output capture_time, output read_channel,
                   input ready);
   modport sink   (input valid, input cmd, input capture_time, input read_channel,
                   output ready);
endinterface

interface pdec_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] channel_width_x2;
   logic [15:0] echo_width;
   logic        awaiting_fall;
   logic        link_active;
   logic [3:0]  frame_index;

   modport source (output valid, output channel_width_x2, output echo_width,
                   output awaiting_fall, output link_active, output frame_index,
                   input ready);
   modport sink   (input valid, input channel_width_x2, input echo_width,
                   input awaiting_fall, input link_active, input frame_index,
                   output ready);
endinterface

// ----- rtl/pdec_ppm.sv -----
// PPM frame tracker: gap measurement, channel index and channel width store
`timescale 1ns / 1ps
module pdec_ppm #(
   parameter int unsigned NUM_CHANNELS = pdec_pkg::MAX_CHANNELS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  hit,
   input  logic [pdec_pkg::TIME_W-1:0]           capture_time,
   input  logic [pdec_pkg::CHAN_W-1:0]           read_channel,
   input  pdec_pkg::ppm_cfg_type                 cfg,
   output logic [pdec_pkg::TIME_W:0]             width_x2,
   output pdec_pkg::ppm_status_type              status_in
);
   import pdec_pkg::*;

   localparam logic [INDEX_W-1:0] NUM_CH = INDEX_W'(NUM_CHANNELS);

   logic [TIME_W-1:0]  last_ff;
   logic [TIME_W-1:0]  last_in;
   logic               active_ff;
   logic               active_in;
   logic [INDEX_W-1:0] index_ff;
   logic [INDEX_W-1:0] index_in;
   logic [TIME_W-1:0]  widths_ff [STORE_DEPTH];
   logic [TIME_W-1:0]  widths_in [STORE_DEPTH];

   logic [TIME_W-1:0]  gap;
   logic               is_sync;
   logic               in_window;
   logic               store;
   logic               idx_room;

   always_comb begin
      gap       = capture_time - last_ff;   // wraps mod 2^16
      is_sync   = gap > cfg.sync_gap;
      in_window = (gap > cfg.min_width) && (gap < cfg.max_width);
      idx_room  = index_ff < NUM_CH;
      store     = hit && !is_sync && in_window && idx_room;

      last_in   = hit ? capture_time : last_ff;
      active_in = hit | active_ff;
      index_in  = index_ff;
      if (hit) begin
         if (is_sync) begin
            index_in = '0;
         end else if (idx_room) begin
            index_in = index_ff + INDEX_W'(1);
         end
      end

      for (int i = 0; i < STORE_DEPTH; i++) begin
         widths_in[i] = widths_ff[i];
         if (store && (index_ff[CHAN_W-1:0] == CHAN_W'(i))) begin
            widths_in[i] = gap;
         end
      end

      // result reflects this beat's update
      if ({1'b0, read_channel} < NUM_CH) begin
         width_x2 = {widths_in[read_channel], 1'b0};
      end else begin
         width_x2 = '0;
      end

      status_in.active = active_in;
      status_in.index  = index_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= '0;
         active_ff <= 1'b0;
         index_ff  <= '0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            widths_ff[i] <= WIDTH_CENTER;
         end
      end else begin
         last_ff   <= last_in;
         active_ff <= active_in;
         index_ff  <= index_in;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            widths_ff[i] <= widths_in[i];
         end
      end
   end

endmodule

// ----- rtl/ppm_and_echo_pulse_decoder.sv -----
// Top level: PPM sum-signal and sonar echo pulse decoder
// Path: a request beat passes the input register, then the result register.
// Throughput: one beat per cycle; while a response waits, only one more request is taken.
// The gap subtract and window compares sit between the two registers.
// Reset (synchronous, active high): config to 2700/750/2250, all channel widths to 1500,
// sonar waits for a rising edge, index, link flag and timestamps cleared.
`timescale 1ns / 1ps
module ppm_and_echo_pulse_decoder #(
   parameter int unsigned NUM_CHANNELS = pdec_pkg::MAX_CHANNELS
) (
   input  logic                                clock,
   input  logic                                reset,
   pdec_req_if.sink                            req_bus,
   pdec_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [pdec_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pdec_pkg::TIME_W-1:0]         csr_wdata
);
   import pdec_pkg::*;

   ppm_cfg_type cfg_ff;

   // input stage
   logic              s1_valid_ff;
   logic [1:0]        s1_cmd_ff;
   logic [TIME_W-1:0] s1_time_ff;
   logic [CHAN_W-1:0] s1_chan_ff;

   // result stage
   logic               rsp_valid_ff;
   logic [TIME_W:0]    rsp_width_ff;
   logic [TIME_W-1:0]  rsp_echo_ff;
   logic               rsp_fall_ff;
   logic               rsp_active_ff;
   logic [INDEX_W-1:0] rsp_index_ff;

   // sonar state
   logic              phase_ff;
   logic              phase_in;
   logic [TIME_W-1:0] rise_ff;
   logic [TIME_W-1:0] rise_in;
   logic [TIME_W-1:0] echo_ff;
   logic [TIME_W-1:0] echo_in;

   logic           advance;
   logic           ppm_hit;
   logic [TIME_W:0] width_x2;
   ppm_status_type ppm_status;

   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign ppm_hit       = advance && (s1_cmd_ff == CMD_PPM);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_gap  <= RST_SYNC_GAP;
         cfg_ff.min_width <= RST_MIN_WIDTH;
         cfg_ff.max_width <= RST_MAX_WIDTH;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYNC_GAP:  cfg_ff.sync_gap  <= csr_wdata;
            CSR_MIN_WIDTH: cfg_ff.min_width <= csr_wdata;
            CSR_MAX_WIDTH: cfg_ff.max_width <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      rise_in  = rise_ff;
      echo_in  = echo_ff;
      if (advance) begin
         case (s1_cmd_ff)
            CMD_SONAR: begin
               if (!phase_ff) begin
                  rise_in  = s1_time_ff;
                  phase_in = 1'b1;
               end else begin
                  if (s1_time_ff > rise_ff) begin
                     echo_in = s1_time_ff - rise_ff;
                  end else begin
                     echo_in = (TIMER_TOP - rise_ff) + s1_time_ff;
                  end
                  phase_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   pdec_ppm #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_ppm (
      .clock        (clock),
      .reset        (reset),
      .hit          (ppm_hit),
      .capture_time (s1_time_ff),
      .read_channel (s1_chan_ff),
      .cfg          (cfg_ff),
      .width_x2     (width_x2),
      .status_in    (ppm_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         rise_ff      <= '0;
         echo_ff      <= '0;
      end else begin
         phase_ff <= phase_in;
         rise_ff  <= rise_in;
         echo_ff  <= echo_in;
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         s1_cmd_ff  <= req_bus.cmd;
         s1_time_ff <= req_bus.capture_time;
         s1_chan_ff <= req_bus.read_channel;
      end
      if (advance) begin
         rsp_width_ff  <= width_x2;
         rsp_echo_ff   <= echo_in;
         rsp_fall_ff   <= phase_in;
         rsp_active_ff <= ppm_status.active;
         rsp_index_ff  <= ppm_status.index;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.channel_width_x2 = rsp_width_ff;
   assign rsp_bus.echo_width       = rsp_echo_ff;
   assign rsp_bus.awaiting_fall    = rsp_fall_ff;
   assign rsp_bus.link_active      = rsp_active_ff;
   assign rsp_bus.frame_index      = rsp_index_ff;

   // index never passes the channel count
   a_index_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_index_ff <= INDEX_W'(NUM_CHANNELS)))
      else $error("frame index above channel count");

   // a finished beat always lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result lost on advance");

   // a rising sonar edge arms the fall wait
   a_sonar_arm: assert property (@(posedge clock) disable iff (reset)
      (advance && (s1_cmd_ff == CMD_SONAR) && !phase_ff) |=> phase_ff)
      else $error("sonar rise did not arm");

   // once the link is seen it stays seen until reset
   a_link_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_active_ff && advance) |=> rsp_active_ff)
      else $error("link flag dropped");

endmodule
